[design/mcic_pkg.sv]
package mcic_pkg;

	// default grid limits and variable set count
	localparam int MAX_I_DEF    = 64;
	localparam int MAX_J_DEF    = 64;
	localparam int MAX_K_DEF    = 16;
	localparam int VAR_SETS_DEF = 8;

	// front to back queue depth
	localparam int QUEUE_DEPTH = 2;

	// opcodes
	localparam logic [1:0] OP_RESTART = 2'd0;
	localparam logic [1:0] OP_LOAD    = 2'd1;
	localparam logic [1:0] OP_LOOKUP  = 2'd2;

	// config register indexes
	localparam logic [2:0] REG_DIM_I  = 3'd0;
	localparam logic [2:0] REG_DIM_J  = 3'd1;
	localparam logic [2:0] REG_DIM_K  = 3'd2;
	localparam logic [2:0] REG_ACTIVE = 3'd3;
	localparam logic [2:0] REG_GHOST  = 3'd4;

	localparam logic signed [19:0] NONE_INDEX = -20'sd1;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [3:0]        cell_status;
		logic signed [7:0] pos_i;
		logic signed [7:0] pos_j;
		logic signed [7:0] pos_k;
		logic [2:0]        var_set;
	} mcic_in_t;

	typedef struct packed {
		logic signed [19:0] cell_index;
		logic [16:0]        kept_count;
		logic               rejected;
	} mcic_out_t;

	typedef enum logic [1:0] {
		CMD_PLAIN,
		CMD_WRITE,
		CMD_READ
	} mcic_cmd_kind_t;

	typedef struct packed {
		mcic_cmd_kind_t kind;
		logic [19:0]    offset;
		mcic_out_t      res;
	} mcic_cmd_t;

	typedef enum logic {
		FR_IDLE,
		FR_LOOKUP
	} mcic_fr_state_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} mcic_bk_state_t;

endpackage

[design/mcic_ram.sv]
module mcic_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [W-1:0]                          wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [W-1:0]                          rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/mcic_queue.sv]
module mcic_queue #(
	parameter int W     = 8,
	parameter int DEPTH = mcic_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign dout    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

[design/mcic_front.sv]
module mcic_front #(
	parameter int MAX_I    = mcic_pkg::MAX_I_DEF,
	parameter int MAX_J    = mcic_pkg::MAX_J_DEF,
	parameter int MAX_K    = mcic_pkg::MAX_K_DEF,
	parameter int VAR_SETS = mcic_pkg::VAR_SETS_DEF,
	localparam int DEPTH   = MAX_I * MAX_J * MAX_K,
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  mcic_pkg::mcic_in_t  item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [6:0]          cfg_data,
	input  logic                q_full,
	output logic                q_push,
	output mcic_pkg::mcic_cmd_t q_cmd,
	output logic [AW-1:0]       q_addr,
	output logic [AW:0]         q_wdata
);

	localparam int CW   = AW + 1;
	localparam int NI_W = $clog2(MAX_I + 1);
	localparam int NJ_W = $clog2(MAX_J + 1);
	localparam int NK_W = $clog2(MAX_K + 1);
	localparam int IJ_W = $clog2(MAX_I * MAX_J + 1);
	localparam int KXW  = (CW > 20) ? CW : 20;

	mcic_pkg::mcic_fr_state_t state_q, state_d;

	logic [6:0]      dim_i_q;
	logic [6:0]      dim_j_q;
	logic [4:0]      dim_k_q;
	logic [3:0]      active_q;
	logic [3:0]      ghost_q;
	logic [1:0]      settle_q;
	logic [IJ_W-1:0] ij_q;
	logic [CW-1:0]   size_q;
	logic [CW-1:0]   pos_q;
	logic [CW-1:0]   kept_q;

	logic            hit_s1;
	logic [6:0]      pi_s1;
	logic [AW-1:0]   t_s1;
	logic [2:0]      vs_s1;

	logic [NI_W-1:0] ni;
	logic [NJ_W-1:0] nj;
	logic [NK_W-1:0] nk;
	logic            acc;
	logic            cfg_wr;
	logic            keep;
	logic            over;
	logic            hit;
	logic [CW-1:0]   kept_inc;
	logic [KXW-1:0]  kept_ext;
	logic [KXW-1:0]  inc_ext;
	logic [AW-1:0]   lk_addr;
	logic [19:0]     lk_offset;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;

	// dimensions above the build limit act as the limit
	assign ni = (32'(dim_i_q) > MAX_I) ? NI_W'(MAX_I) : NI_W'(dim_i_q);
	assign nj = (32'(dim_j_q) > MAX_J) ? NJ_W'(MAX_J) : NJ_W'(dim_j_q);
	assign nk = (32'(dim_k_q) > MAX_K) ? NK_W'(MAX_K) : NK_W'(dim_k_q);

	assign acc      = push && !full;
	assign keep     = (item.cell_status == active_q) || (item.cell_status == ghost_q);
	assign over     = (pos_q >= size_q);
	assign kept_inc = kept_q + CW'(keep);
	assign kept_ext = KXW'(kept_q);
	assign inc_ext  = KXW'(kept_inc);

	assign hit = !item.pos_i[7] && (32'(item.pos_i[6:0]) < 32'(ni)) &&
	             !item.pos_j[7] && (32'(item.pos_j[6:0]) < 32'(nj)) &&
	             !item.pos_k[7] && (32'(item.pos_k[6:0]) < 32'(nk)) &&
	             (32'(item.var_set) < VAR_SETS);

	// second half of the address and the set offset
	assign lk_addr   = AW'(32'(pi_s1) + 32'(ni) * 32'(t_s1));
	assign lk_offset = 20'(32'(vs_s1) * 32'(kept_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcic_pkg::FR_IDLE: begin
				if (acc && item.opcode == mcic_pkg::OP_LOOKUP) begin
					state_d = mcic_pkg::FR_LOOKUP;
				end
			end
			mcic_pkg::FR_LOOKUP: begin
				if (!q_full) begin
					state_d = mcic_pkg::FR_IDLE;
				end
			end
			default: state_d = mcic_pkg::FR_IDLE;
		endcase
	end

	always_comb begin
		full                   = (state_q != mcic_pkg::FR_IDLE) || (settle_q != '0) || q_full;
		q_push                 = 1'b0;
		q_cmd                  = '0;
		q_cmd.kind             = mcic_pkg::CMD_PLAIN;
		q_cmd.res.cell_index   = mcic_pkg::NONE_INDEX;
		q_cmd.res.kept_count   = kept_ext[16:0];
		q_addr                 = pos_q[AW-1:0];
		q_wdata                = {keep, kept_q[AW-1:0]};
		unique case (state_q)
			mcic_pkg::FR_IDLE: begin
				if (acc) begin
					unique case (item.opcode)
						mcic_pkg::OP_RESTART: begin
							q_push               = 1'b1;
							q_cmd.res.kept_count = '0;
						end
						mcic_pkg::OP_LOAD: begin
							q_push = 1'b1;
							if (over) begin
								q_cmd.res.rejected = 1'b1;
							end else begin
								q_cmd.kind           = mcic_pkg::CMD_WRITE;
								q_cmd.res.kept_count = inc_ext[16:0];
								if (keep) begin
									q_cmd.res.cell_index = kept_ext[19:0];
								end
							end
						end
						mcic_pkg::OP_LOOKUP: begin
							q_push = 1'b0;
						end
						default: begin
							q_push = 1'b1;
						end
					endcase
				end
			end
			mcic_pkg::FR_LOOKUP: begin
				q_push       = !q_full;
				q_cmd.kind   = hit_s1 ? mcic_pkg::CMD_READ : mcic_pkg::CMD_PLAIN;
				q_cmd.offset = lk_offset;
				q_addr       = lk_addr;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mcic_pkg::FR_IDLE;
			dim_i_q  <= 7'd64;
			dim_j_q  <= 7'd64;
			dim_k_q  <= 5'd16;
			active_q <= 4'd0;
			ghost_q  <= 4'd1;
			settle_q <= 2'd2;
			pos_q    <= '0;
			kept_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				settle_q <= 2'd2;
				unique case (cfg_index)
					mcic_pkg::REG_DIM_I:  dim_i_q  <= cfg_data;
					mcic_pkg::REG_DIM_J:  dim_j_q  <= cfg_data;
					mcic_pkg::REG_DIM_K:  dim_k_q  <= cfg_data[4:0];
					mcic_pkg::REG_ACTIVE: active_q <= cfg_data[3:0];
					mcic_pkg::REG_GHOST:  ghost_q  <= cfg_data[3:0];
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
			if (acc && item.opcode == mcic_pkg::OP_RESTART) begin
				pos_q  <= '0;
				kept_q <= '0;
			end else if (acc && item.opcode == mcic_pkg::OP_LOAD && !over) begin
				pos_q  <= pos_q + 1'b1;
				kept_q <= kept_inc;
			end
		end
	end

	// grid size, two products in series
	always_ff @(posedge clk) begin
		ij_q   <= IJ_W'(ni) * IJ_W'(nj);
		size_q <= CW'(ij_q) * CW'(nk);
	end

	always_ff @(posedge clk) begin
		if (acc && item.opcode == mcic_pkg::OP_LOOKUP) begin
			hit_s1 <= hit;
			pi_s1  <= item.pos_i[6:0];
			t_s1   <= AW'(32'(item.pos_j[6:0]) + 32'(nj) * 32'(item.pos_k[6:0]));
			vs_s1  <= item.var_set;
		end
	end

endmodule

[design/mcic_back.sv]
module mcic_back #(
	parameter int MAX_I  = mcic_pkg::MAX_I_DEF,
	parameter int MAX_J  = mcic_pkg::MAX_J_DEF,
	parameter int MAX_K  = mcic_pkg::MAX_K_DEF,
	localparam int DEPTH = MAX_I * MAX_J * MAX_K,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  mcic_pkg::mcic_cmd_t q_cmd,
	input  logic [AW-1:0]       q_addr,
	input  logic [AW:0]         q_wdata,
	output logic                empty,
	input  logic                pop,
	output mcic_pkg::mcic_out_t result
);

	localparam int EW = (AW > 20) ? AW : 20;

	mcic_pkg::mcic_bk_state_t state_q, state_d;

	mcic_pkg::mcic_cmd_t cmd_q;
	mcic_pkg::mcic_out_t out_q;
	mcic_pkg::mcic_out_t out_d;
	logic                out_valid_q;
	logic                out_load;
	logic                out_free;
	logic                ram_we;
	logic                ram_re;
	logic [AW:0]         ram_rdata;
	logic [EW-1:0]       e_ext;
	logic signed [19:0]  lk_index;

	// entry: kept flag on top, dense index below
	mcic_ram #(
		.W     (AW + 1),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (q_addr),
		.wdata (q_wdata),
		.re    (ram_re),
		.raddr (q_addr),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || pop;
	assign e_ext    = EW'(ram_rdata[AW-1:0]);
	assign lk_index = ram_rdata[AW] ? (e_ext[19:0] + cmd_q.offset) : mcic_pkg::NONE_INDEX;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcic_pkg::BK_IDLE: begin
				if (!q_empty && out_free && q_cmd.kind == mcic_pkg::CMD_READ) begin
					state_d = mcic_pkg::BK_READ;
				end
			end
			mcic_pkg::BK_READ: begin
				if (out_free) begin
					state_d = mcic_pkg::BK_IDLE;
				end
			end
			default: state_d = mcic_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		out_load = 1'b0;
		out_d    = q_cmd.res;
		unique case (state_q)
			mcic_pkg::BK_IDLE: begin
				q_pop = !q_empty && out_free;
				if (q_pop) begin
					unique case (q_cmd.kind)
						mcic_pkg::CMD_WRITE: begin
							ram_we   = 1'b1;
							out_load = 1'b1;
						end
						mcic_pkg::CMD_READ: begin
							ram_re = 1'b1;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			mcic_pkg::BK_READ: begin
				out_load         = out_free;
				out_d            = cmd_q.res;
				out_d.cell_index = lk_index;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mcic_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			cmd_q <= q_cmd;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

[design/mesh_cell_index_compactor_unit.sv]
// Dense index map over a 3D grid of cells. A restart item clears the load
// position and kept count; load items bring cell status codes in raster
// order (i fastest, then k last) and each cell matching the active or ghost
// code gets the next dense index, others get -1; loads past the configured
// grid are rejected. A lookup item maps (i, j, k, var_set) to the stored
// index plus var_set times the kept count, or -1 for an unkept cell, a
// position outside the grid or a var_set of VAR_SETS or more. Every item
// gives exactly one result item. Timing: the front takes one restart or
// load item per cycle while the queue is not full, and none while a lookup
// passes the two chained address multiplies; the back likewise while the
// result register is free, and none while a lookup waits on its registered
// table read. A two entry queue sits between front and back and a result
// register at the output, so input and output stall independently. After
// reset and after every config write, full stays high while the grid size
// product updates. The user must write config only while idle; the block
// does not enforce it. The table holds MAX_I*MAX_J*MAX_K entries with no
// clearing pass; looking up an unloaded cell returns an unspecified value.
module mesh_cell_index_compactor_unit #(
	parameter int MAX_I    = mcic_pkg::MAX_I_DEF,
	parameter int MAX_J    = mcic_pkg::MAX_J_DEF,
	parameter int MAX_K    = mcic_pkg::MAX_K_DEF,
	parameter int VAR_SETS = mcic_pkg::VAR_SETS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input item channel
	input  logic                push,
	output logic                full,
	input  mcic_pkg::mcic_in_t  item,
	// result channel
	output logic                empty,
	input  logic                pop,
	output mcic_pkg::mcic_out_t result,
	// config write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [6:0]          cfg_data
);

	localparam int DEPTH = MAX_I * MAX_J * MAX_K;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMD_W = $bits(mcic_pkg::mcic_cmd_t);
	localparam int QW    = CMD_W + AW + AW + 1;

	// front side of the command queue
	logic                f_push;
	logic                f_full;
	mcic_pkg::mcic_cmd_t f_cmd;
	logic [AW-1:0]       f_addr;
	logic [AW:0]         f_wdata;

	// back side of the command queue
	logic                b_pop;
	logic                b_empty;
	mcic_pkg::mcic_cmd_t b_cmd;
	logic [AW-1:0]       b_addr;
	logic [AW:0]         b_wdata;

	logic [QW-1:0]       q_din;
	logic [QW-1:0]       q_dout;

	// front: config registers, load position and kept count, address math
	mcic_front #(
		.MAX_I    (MAX_I),
		.MAX_J    (MAX_J),
		.MAX_K    (MAX_K),
		.VAR_SETS (VAR_SETS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (f_full),
		.q_push    (f_push),
		.q_cmd     (f_cmd),
		.q_addr    (f_addr),
		.q_wdata   (f_wdata)
	);

	// command word: {cmd, table address, table write data}
	assign q_din = {f_cmd, f_addr, f_wdata};

	mcic_queue #(
		.W     (QW),
		.DEPTH (mcic_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.full   (f_full),
		.din    (q_din),
		.pop    (b_pop),
		.empty  (b_empty),
		.dout   (q_dout)
	);

	assign b_cmd   = q_dout[QW-1 -: CMD_W];
	assign b_addr  = q_dout[AW+AW : AW+1];
	assign b_wdata = q_dout[AW:0];

	// back: index table writes and reads, result register
	mcic_back #(
		.MAX_I (MAX_I),
		.MAX_J (MAX_J),
		.MAX_K (MAX_K)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (b_empty),
		.q_pop   (b_pop),
		.q_cmd   (b_cmd),
		.q_addr  (b_addr),
		.q_wdata (b_wdata),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
